// ===== src/sgr_pkg.sv =====
// shared types and constants for the sgr attribute tracker
`default_nettype none

package sgr_pkg;

  localparam int unsigned ParamW    = 16;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned KindW     = 2;
  localparam int unsigned StyleW    = 8;
  localparam int unsigned BlinkW    = 2;
  localparam int unsigned FontW     = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEF_FG_KIND  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEF_FG_VALUE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEF_BG_KIND  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DEF_BG_VALUE = 3'd3;

  // colour kinds
  localparam logic [KindW-1:0] KIND_SYSTEM    = 2'd1;
  localparam logic [KindW-1:0] KIND_INDEXED   = 2'd2;
  localparam logic [KindW-1:0] KIND_TRUECOLOR = 2'd3;

  // blink modes
  localparam logic [BlinkW-1:0] BLINK_NONE = 2'd0;
  localparam logic [BlinkW-1:0] BLINK_SLOW = 2'd1;
  localparam logic [BlinkW-1:0] BLINK_FAST = 2'd2;

  // style flag bits
  localparam int unsigned ST_BOLD      = 0;
  localparam int unsigned ST_FAINT     = 1;
  localparam int unsigned ST_ITALIC    = 2;
  localparam int unsigned ST_UNDERLINE = 3;
  localparam int unsigned ST_REVERSE   = 4;
  localparam int unsigned ST_CONCEAL   = 5;
  localparam int unsigned ST_CROSSED   = 6;
  localparam int unsigned ST_FRAKTUR   = 7;

  // sgr codes with special handling
  localparam logic [ParamW-1:0] SGR_FG_EXT     = 16'd38;
  localparam logic [ParamW-1:0] SGR_BG_EXT     = 16'd48;
  localparam logic [ParamW-1:0] SGR_FG_DEFAULT = 16'd39;
  localparam logic [ParamW-1:0] SGR_BG_DEFAULT = 16'd49;
  localparam logic [ParamW-1:0] SEL_INDEXED    = 16'd5;
  localparam logic [ParamW-1:0] SEL_TRUECOLOR  = 16'd2;
  localparam logic [ParamW-1:0] SGR_FONT_BASE  = 16'd10;

  // extended colour phase
  typedef enum logic [3:0] {
    PH_NORMAL   = 4'd0,
    PH_FG_SEL   = 4'd1,
    PH_BG_SEL   = 4'd2,
    PH_FG_INDEX = 4'd3,
    PH_BG_INDEX = 4'd4,
    PH_FG_RED   = 4'd5,
    PH_BG_RED   = 4'd6,
    PH_FG_GREEN = 4'd7,
    PH_BG_GREEN = 4'd8,
    PH_FG_BLUE  = 4'd9,
    PH_BG_BLUE  = 4'd10
  } phase_t;

  typedef struct packed {
    logic [StyleW-1:0] style;
    logic [BlinkW-1:0] blink;
    logic [FontW-1:0]  font;
    logic [KindW-1:0]  fg_kind;
    logic [ColorW-1:0] fg_value;
    logic [KindW-1:0]  bg_kind;
    logic [ColorW-1:0] bg_value;
  } attr_t;

  typedef struct packed {
    logic [KindW-1:0]  fg_kind;
    logic [ColorW-1:0] fg_value;
    logic [KindW-1:0]  bg_kind;
    logic [ColorW-1:0] bg_value;
  } defaults_t;

endpackage

`default_nettype wire

// ===== src/sgr_ifaces.sv =====
// valid/ready channel interfaces for parameters and attributes
`default_nettype none

interface sgr_param_if;
  logic        valid;
  logic        ready;
  logic [15:0] param_value;
  logic        first_of_sequence;

  modport source (output valid, param_value, first_of_sequence, input ready);
  modport sink (input valid, param_value, first_of_sequence, output ready);
endinterface

interface sgr_attr_if;
  logic        valid;
  logic        ready;
  logic [7:0]  style_flags;
  logic [1:0]  blink_mode;
  logic [3:0]  font_select;
  logic [1:0]  fg_kind;
  logic [23:0] fg_value;
  logic [1:0]  bg_kind;
  logic [23:0] bg_value;

  modport source (output valid, style_flags, blink_mode, font_select,
                  fg_kind, fg_value, bg_kind, bg_value, input ready);
  modport sink (input valid, style_flags, blink_mode, font_select,
                fg_kind, fg_value, bg_kind, bg_value, output ready);
endinterface

`default_nettype wire

// ===== src/sgr_decode.sv =====
// next attribute and extended colour phase for one sgr parameter
`default_nettype none

module sgr_decode
  import sgr_pkg::*;
(
  input  attr_t              cur,
  input  phase_t             phase,
  input  defaults_t          defaults,
  input  logic [ParamW-1:0]  param,
  input  logic               first,
  output attr_t              nxt,
  output phase_t             phase_next
);

  phase_t           ph;
  logic [7:0]       byte_val;
  logic [FontW-1:0] font_num;

  assign byte_val = param[7:0];
  assign font_num = FontW'(param - SGR_FONT_BASE);

  always_comb begin
    nxt        = cur;
    phase_next = PH_NORMAL;
    // a new sequence drops any pending extended form
    ph         = first ? PH_NORMAL : phase;

    unique case (ph)
      PH_FG_SEL, PH_BG_SEL: begin
        if (param == SEL_INDEXED) begin
          phase_next = (ph == PH_FG_SEL) ? PH_FG_INDEX : PH_BG_INDEX;
        end else if (param == SEL_TRUECOLOR) begin
          phase_next = (ph == PH_FG_SEL) ? PH_FG_RED : PH_BG_RED;
          if (ph == PH_FG_SEL) begin
            nxt.fg_kind  = KIND_TRUECOLOR;
            nxt.fg_value = '0;
          end else begin
            nxt.bg_kind  = KIND_TRUECOLOR;
            nxt.bg_value = '0;
          end
        end
      end
      PH_FG_INDEX: begin
        nxt.fg_kind  = KIND_INDEXED;
        nxt.fg_value = {16'd0, byte_val};
      end
      PH_BG_INDEX: begin
        nxt.bg_kind  = KIND_INDEXED;
        nxt.bg_value = {16'd0, byte_val};
      end
      PH_FG_RED: begin
        nxt.fg_value[23:16] = byte_val;
        phase_next          = PH_FG_GREEN;
      end
      PH_BG_RED: begin
        nxt.bg_value[23:16] = byte_val;
        phase_next          = PH_BG_GREEN;
      end
      PH_FG_GREEN: begin
        nxt.fg_value[15:8] = byte_val;
        phase_next         = PH_FG_BLUE;
      end
      PH_BG_GREEN: begin
        nxt.bg_value[15:8] = byte_val;
        phase_next         = PH_BG_BLUE;
      end
      PH_FG_BLUE: nxt.fg_value[7:0] = byte_val;
      PH_BG_BLUE: nxt.bg_value[7:0] = byte_val;
      default: begin
        // normal parameter
        case (param) inside
          16'd0: begin
            nxt.style    = '0;
            nxt.blink    = BLINK_NONE;
            nxt.font     = '0;
            nxt.fg_kind  = defaults.fg_kind;
            nxt.fg_value = defaults.fg_value;
            nxt.bg_kind  = defaults.bg_kind;
            nxt.bg_value = defaults.bg_value;
          end
          16'd1:  nxt.style[ST_BOLD]      = 1'b1;
          16'd2:  nxt.style[ST_FAINT]     = 1'b1;
          16'd3:  nxt.style[ST_ITALIC]    = 1'b1;
          16'd4:  nxt.style[ST_UNDERLINE] = 1'b1;
          16'd5:  nxt.blink               = BLINK_SLOW;
          16'd6:  nxt.blink               = BLINK_FAST;
          16'd7:  nxt.style[ST_REVERSE]   = 1'b1;
          16'd8:  nxt.style[ST_CONCEAL]   = 1'b1;
          16'd9:  nxt.style[ST_CROSSED]   = 1'b1;
          16'd20: nxt.style[ST_FRAKTUR]   = 1'b1;
          16'd21: nxt.style[ST_BOLD]      = 1'b0;
          16'd22: begin
            nxt.style[ST_BOLD]  = 1'b0;
            nxt.style[ST_FAINT] = 1'b0;
          end
          16'd23: begin
            nxt.style[ST_ITALIC]  = 1'b0;
            nxt.style[ST_FRAKTUR] = 1'b0;
          end
          16'd24: nxt.style[ST_UNDERLINE] = 1'b0;
          16'd25: nxt.blink               = BLINK_NONE;
          16'd27: nxt.style[ST_REVERSE]   = 1'b0;
          16'd28: nxt.style[ST_CONCEAL]   = 1'b0;
          16'd29: nxt.style[ST_CROSSED]   = 1'b0;
          SGR_FG_EXT: phase_next = PH_FG_SEL;
          SGR_BG_EXT: phase_next = PH_BG_SEL;
          SGR_FG_DEFAULT: begin
            nxt.fg_kind  = defaults.fg_kind;
            nxt.fg_value = defaults.fg_value;
          end
          SGR_BG_DEFAULT: begin
            nxt.bg_kind  = defaults.bg_kind;
            nxt.bg_value = defaults.bg_value;
          end
          [16'd10:16'd19]: nxt.font = font_num;
          [16'd30:16'd37], [16'd90:16'd97]: begin
            nxt.fg_kind  = KIND_SYSTEM;
            nxt.fg_value = {8'd0, param};
          end
          [16'd40:16'd47], [16'd100:16'd107]: begin
            nxt.bg_kind  = KIND_SYSTEM;
            nxt.bg_value = {8'd0, param};
          end
          default: ;
        endcase
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/sgr_out_buf.sv =====
// two-entry output buffer with registered ready toward the producer
`default_nettype none

module sgr_out_buf
  import sgr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  attr_t push_data,
  output logic  push_ready,
  output logic  out_valid,
  output attr_t out_data,
  input  logic  out_ready
);

  logic  skid_valid;
  attr_t skid_data;

  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        out_data  <= push_data;
      end
    end else if (push) begin
      // output stalled, park the beat
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/sgr_attribute_tracker.sv =====
// top level of the sgr attribute tracker
//
// param_in carries one sgr parameter per beat (param_value, saturated to
// 16 bits, and first_of_sequence marking the first parameter of a sequence).
// attr_out returns one beat per accepted parameter: the full current text
// attribute (style flags, blink mode, font, fg and bg colour kind and value)
// after that parameter has been applied.
// the result of an accepted parameter goes into a register of the output buffer.
// throughput: one parameter per cycle while param_in.ready is high; the attribute
// state and the 38/48 extended colour phase are updated from a combinational decode.
// a two-entry output buffer decouples the sides: param_in.ready comes from a
// register and stays high while the receiver takes beats; if attr_out is
// stalled one more beat is parked, then param_in.ready drops until a
// beat leaves.
// the cfg port writes the default colours (cfg_index 0..3); writes change
// only the defaults used by codes 0, 39 and 49, not the current colours.
// reset (rst, synchronous) clears the defaults, the attribute and the
// extended phase, and empties the output buffer.
`default_nettype none

module sgr_attribute_tracker
  import sgr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  sgr_param_if.sink                param_in,
  sgr_attr_if.source               attr_out
);

  defaults_t defaults;
  attr_t     attr;
  attr_t     attr_next;
  phase_t    phase;
  phase_t    phase_next;
  logic      accept;
  attr_t     out_data;

  // default colour registers
  always_ff @(posedge clk) begin
    if (rst) begin
      defaults <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEF_FG_KIND:  defaults.fg_kind  <= cfg_data[KindW-1:0];
        CFG_DEF_FG_VALUE: defaults.fg_value <= cfg_data[ColorW-1:0];
        CFG_DEF_BG_KIND:  defaults.bg_kind  <= cfg_data[KindW-1:0];
        CFG_DEF_BG_VALUE: defaults.bg_value <= cfg_data[ColorW-1:0];
        default: ;
      endcase
    end
  end

  assign accept = param_in.valid && param_in.ready;

  sgr_decode u_decode (
    .cur        (attr),
    .phase      (phase),
    .defaults   (defaults),
    .param      (param_in.param_value),
    .first      (param_in.first_of_sequence),
    .nxt        (attr_next),
    .phase_next (phase_next)
  );

  // current attribute and extended colour phase
  always_ff @(posedge clk) begin
    if (rst) begin
      attr  <= '0;
      phase <= PH_NORMAL;
    end else if (accept) begin
      attr  <= attr_next;
      phase <= phase_next;
    end
  end

  sgr_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (attr_next),
    .push_ready (param_in.ready),
    .out_valid  (attr_out.valid),
    .out_data   (out_data),
    .out_ready  (attr_out.ready)
  );

  assign attr_out.style_flags = out_data.style;
  assign attr_out.blink_mode  = out_data.blink;
  assign attr_out.font_select = out_data.font;
  assign attr_out.fg_kind     = out_data.fg_kind;
  assign attr_out.fg_value    = out_data.fg_value;
  assign attr_out.bg_kind     = out_data.bg_kind;
  assign attr_out.bg_value    = out_data.bg_value;

endmodule

`default_nettype wire

// ===== sim/sgr_tb_pkg.sv =====
// sgr code points and helper constants shared by the checker and the testbench top
`timescale 1ns / 1ps

package sgr_tb_pkg;

  import sgr_pkg::*;

  localparam logic [KindW-1:0]  KIND_DEFAULT = 2'd0;
  localparam logic [ParamW-1:0] PARAM_MAX    = 16'hFFFF;

  // plain sgr codes
  localparam logic [ParamW-1:0] SGR_RESET           = 16'd0;
  localparam logic [ParamW-1:0] SGR_BOLD            = 16'd1;
  localparam logic [ParamW-1:0] SGR_FAINT           = 16'd2;
  localparam logic [ParamW-1:0] SGR_ITALIC          = 16'd3;
  localparam logic [ParamW-1:0] SGR_UNDERLINE       = 16'd4;
  localparam logic [ParamW-1:0] SGR_SLOW_BLINK      = 16'd5;
  localparam logic [ParamW-1:0] SGR_FAST_BLINK      = 16'd6;
  localparam logic [ParamW-1:0] SGR_REVERSE         = 16'd7;
  localparam logic [ParamW-1:0] SGR_CONCEAL         = 16'd8;
  localparam logic [ParamW-1:0] SGR_CROSSED         = 16'd9;
  localparam logic [ParamW-1:0] SGR_FONT_FIRST      = 16'd10;
  localparam logic [ParamW-1:0] SGR_FONT_LAST       = 16'd19;
  localparam logic [ParamW-1:0] SGR_FRAKTUR         = 16'd20;
  localparam logic [ParamW-1:0] SGR_NO_BOLD         = 16'd21;
  localparam logic [ParamW-1:0] SGR_NORMAL_WEIGHT   = 16'd22;
  localparam logic [ParamW-1:0] SGR_NO_ITALIC       = 16'd23;
  localparam logic [ParamW-1:0] SGR_NO_UNDERLINE    = 16'd24;
  localparam logic [ParamW-1:0] SGR_NO_BLINK        = 16'd25;
  localparam logic [ParamW-1:0] SGR_UNKNOWN         = 16'd26;
  localparam logic [ParamW-1:0] SGR_NO_REVERSE      = 16'd27;
  localparam logic [ParamW-1:0] SGR_NO_CONCEAL      = 16'd28;
  localparam logic [ParamW-1:0] SGR_NO_CROSSED      = 16'd29;
  localparam logic [ParamW-1:0] SGR_FG_FIRST        = 16'd30;
  localparam logic [ParamW-1:0] SGR_FG_LAST         = 16'd37;
  localparam logic [ParamW-1:0] SGR_BG_FIRST        = 16'd40;
  localparam logic [ParamW-1:0] SGR_BG_LAST         = 16'd47;
  localparam logic [ParamW-1:0] SGR_FG_BRIGHT_FIRST = 16'd90;
  localparam logic [ParamW-1:0] SGR_FG_BRIGHT_LAST  = 16'd97;
  localparam logic [ParamW-1:0] SGR_BG_BRIGHT_FIRST = 16'd100;
  localparam logic [ParamW-1:0] SGR_BG_BRIGHT_LAST  = 16'd107;

endpackage

// ===== sim/sgr_attr_checker.sv =====
// attribute predictor and scoreboard that watches both channels of the tracker
`timescale 1ns / 1ps

module sgr_attr_checker
  import sgr_pkg::*;
  import sgr_tb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  sgr_param_if                param_ch,
  sgr_attr_if                 attr_ch,
  output int unsigned         pending,
  output int unsigned         fail_count
);

  defaults_t   dflt;
  attr_t       cur;
  phase_t      phase;
  attr_t       expected_attrs[$];
  int unsigned attrs_seen = 0;
  int unsigned mismatches = 0;

  assign fail_count = mismatches;

  task automatic report(input string msg);
    $display("[%0t] attr beat %0d: %s", $time, attrs_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string field, input logic [ColorW-1:0] got,
                             input logic [ColorW-1:0] want);
    if (got !== want) begin
      report($sformatf("%s is %0h, want %0h", field, got, want));
    end
  endtask

  function void put_color(input logic fg, input logic [KindW-1:0] kind,
                          input logic [ColorW-1:0] value);
    if (fg) begin
      cur.fg_kind  = kind;
      cur.fg_value = value;
    end else begin
      cur.bg_kind  = kind;
      cur.bg_value = value;
    end
  endfunction

  function void put_byte(input logic fg, input int unsigned lane, input logic [7:0] b);
    if (fg) cur.fg_value[lane*8 +: 8] = b;
    else cur.bg_value[lane*8 +: 8] = b;
  endfunction

  function void decode_code(input logic [ParamW-1:0] n);
    case (n)
      SGR_RESET: begin
        cur.style = '0;
        cur.blink = BLINK_NONE;
        cur.font  = '0;
        put_color(1'b1, dflt.fg_kind, dflt.fg_value);
        put_color(1'b0, dflt.bg_kind, dflt.bg_value);
      end
      SGR_BOLD:          cur.style[ST_BOLD] = 1'b1;
      SGR_FAINT:         cur.style[ST_FAINT] = 1'b1;
      SGR_ITALIC:        cur.style[ST_ITALIC] = 1'b1;
      SGR_UNDERLINE:     cur.style[ST_UNDERLINE] = 1'b1;
      SGR_SLOW_BLINK:    cur.blink = BLINK_SLOW;
      SGR_FAST_BLINK:    cur.blink = BLINK_FAST;
      SGR_REVERSE:       cur.style[ST_REVERSE] = 1'b1;
      SGR_CONCEAL:       cur.style[ST_CONCEAL] = 1'b1;
      SGR_CROSSED:       cur.style[ST_CROSSED] = 1'b1;
      SGR_FRAKTUR:       cur.style[ST_FRAKTUR] = 1'b1;
      SGR_NO_BOLD:       cur.style[ST_BOLD] = 1'b0;
      SGR_NORMAL_WEIGHT: begin
        cur.style[ST_BOLD]  = 1'b0;
        cur.style[ST_FAINT] = 1'b0;
      end
      SGR_NO_ITALIC: begin
        cur.style[ST_ITALIC]  = 1'b0;
        cur.style[ST_FRAKTUR] = 1'b0;
      end
      SGR_NO_UNDERLINE:  cur.style[ST_UNDERLINE] = 1'b0;
      SGR_NO_BLINK:      cur.blink = BLINK_NONE;
      SGR_NO_REVERSE:    cur.style[ST_REVERSE] = 1'b0;
      SGR_NO_CONCEAL:    cur.style[ST_CONCEAL] = 1'b0;
      SGR_NO_CROSSED:    cur.style[ST_CROSSED] = 1'b0;
      SGR_FG_EXT:        phase = PH_FG_SEL;
      SGR_BG_EXT:        phase = PH_BG_SEL;
      SGR_FG_DEFAULT:    put_color(1'b1, dflt.fg_kind, dflt.fg_value);
      SGR_BG_DEFAULT:    put_color(1'b0, dflt.bg_kind, dflt.bg_value);
      default: begin
        if (n >= SGR_FONT_FIRST && n <= SGR_FONT_LAST) begin
          cur.font = FontW'(n - SGR_FONT_BASE);
        end else if ((n >= SGR_FG_FIRST && n <= SGR_FG_LAST) ||
                     (n >= SGR_FG_BRIGHT_FIRST && n <= SGR_FG_BRIGHT_LAST)) begin
          put_color(1'b1, KIND_SYSTEM, ColorW'(n));
        end else if ((n >= SGR_BG_FIRST && n <= SGR_BG_LAST) ||
                     (n >= SGR_BG_BRIGHT_FIRST && n <= SGR_BG_BRIGHT_LAST)) begin
          put_color(1'b0, KIND_SYSTEM, ColorW'(n));
        end
        // anything else leaves the attribute alone
      end
    endcase
  endfunction

  // advances the attribute by one parameter and returns what the block shows after it
  function attr_t apply_param(input logic [ParamW-1:0] n, input logic first);
    logic fg;
    if (first) phase = PH_NORMAL;
    // odd phases belong to the foreground
    fg = phase[0];
    case (phase)
      PH_FG_SEL, PH_BG_SEL: begin
        if (n == SEL_INDEXED) begin
          phase = fg ? PH_FG_INDEX : PH_BG_INDEX;
        end else if (n == SEL_TRUECOLOR) begin
          put_color(fg, KIND_TRUECOLOR, '0);
          phase = fg ? PH_FG_RED : PH_BG_RED;
        end else begin
          phase = PH_NORMAL;
        end
      end
      PH_FG_INDEX, PH_BG_INDEX: begin
        put_color(fg, KIND_INDEXED, ColorW'(n[7:0]));
        phase = PH_NORMAL;
      end
      PH_FG_RED, PH_BG_RED: begin
        put_byte(fg, 2, n[7:0]);
        phase = fg ? PH_FG_GREEN : PH_BG_GREEN;
      end
      PH_FG_GREEN, PH_BG_GREEN: begin
        put_byte(fg, 1, n[7:0]);
        phase = fg ? PH_FG_BLUE : PH_BG_BLUE;
      end
      PH_FG_BLUE, PH_BG_BLUE: begin
        put_byte(fg, 0, n[7:0]);
        phase = PH_NORMAL;
      end
      default: begin
        phase = PH_NORMAL;
        decode_code(n);
      end
    endcase
    return cur;
  endfunction

  always @(posedge clk) begin : watch
    attr_t got;
    attr_t want;
    attr_t predicted;
    if (rst) begin
      dflt  = '0;
      cur   = '0;
      phase = PH_NORMAL;
      expected_attrs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEF_FG_KIND:  dflt.fg_kind  = cfg_data[KindW-1:0];
          CFG_DEF_FG_VALUE: dflt.fg_value = cfg_data[ColorW-1:0];
          CFG_DEF_BG_KIND:  dflt.bg_kind  = cfg_data[KindW-1:0];
          CFG_DEF_BG_VALUE: dflt.bg_value = cfg_data[ColorW-1:0];
          default: ;
        endcase
      end
      // results leave before new parameters enter, a beat never answers its own edge
      if (attr_ch.valid && attr_ch.ready) begin
        got = {attr_ch.style_flags, attr_ch.blink_mode, attr_ch.font_select,
               attr_ch.fg_kind, attr_ch.fg_value, attr_ch.bg_kind, attr_ch.bg_value};
        if (expected_attrs.size() == 0) begin
          report("attribute beat with no parameter outstanding");
        end else begin
          want = expected_attrs.pop_front();
          check_field("style_flags", ColorW'(got.style), ColorW'(want.style));
          check_field("blink_mode", ColorW'(got.blink), ColorW'(want.blink));
          check_field("font_select", ColorW'(got.font), ColorW'(want.font));
          check_field("fg_kind", ColorW'(got.fg_kind), ColorW'(want.fg_kind));
          check_field("fg_value", got.fg_value, want.fg_value);
          check_field("bg_kind", ColorW'(got.bg_kind), ColorW'(want.bg_kind));
          check_field("bg_value", got.bg_value, want.bg_value);
        end
        attrs_seen++;
      end
      if (param_ch.valid && param_ch.ready) begin
        predicted      = apply_param(param_ch.param_value, param_ch.first_of_sequence);
        expected_attrs = {expected_attrs, predicted};
      end
    end
    pending <= expected_attrs.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// stimulus, handshake pacing and verdict for the sgr attribute tracker
`timescale 1ns / 1ps

module tb_top;

  import sgr_pkg::*;
  import sgr_tb_pkg::*;

  localparam int unsigned IDLE_PCT         = 15;    // chance of an idle cycle per side
  localparam int unsigned SINK_HOLD_CYCLES = 80;    // long receiver hold-off
  localparam int unsigned STALL_LIMIT      = 2000;  // cycles without any beat
  localparam int unsigned BEATS_PER_ROUND  = 125;   // random parameters per defaults setting
  localparam int unsigned ROUNDS           = 5;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // pacing controls: src_quiet is read only by the stimulus process,
  // sink_quiet and hold_requests cross over to the receiver process
  logic        src_quiet;
  logic        sink_quiet;
  int unsigned hold_requests;

  int unsigned beats_sent;
  int unsigned attrs_pending;
  int unsigned fail_count;

  sgr_param_if param_ch ();
  sgr_attr_if  attr_ch ();

  sgr_attribute_tracker DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .param_in  (param_ch),
    .attr_out  (attr_ch)
  );

  sgr_attr_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .param_ch   (param_ch),
    .attr_ch    (attr_ch),
    .pending    (attrs_pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // parameter source helpers
  // ---------------------------------------------------------------------------

  // offers one parameter and returns at the edge where it is taken;
  // valid stays high so the next call can follow without a bubble
  task automatic put_param(input logic [ParamW-1:0] value, input logic first);
    while (!src_quiet && $urandom_range(99) < IDLE_PCT) begin
      param_ch.valid <= 1'b0;
      @(posedge clk);
    end
    param_ch.valid             <= 1'b1;
    param_ch.param_value       <= value;
    param_ch.first_of_sequence <= first;
    do @(posedge clk); while (!param_ch.ready);
    beats_sent++;
  endtask

  // drops valid and waits until every attribute beat owed has come back;
  // pending comes from a register in the checker, so the loop always waits on the clock first
  task automatic drain_attrs();
    param_ch.valid <= 1'b0;
    do @(posedge clk); while (attrs_pending != 0);
  endtask

  // writes all four default registers, kind writes carry junk above the kind bits
  task automatic set_defaults(input defaults_t d);
    logic [CfgIdxW-1:0]  idx [4];
    logic [CfgDataW-1:0] data [4];
    logic [CfgDataW-1:0] junk;
    junk    = CfgDataW'($urandom);
    idx[0]  = CFG_DEF_FG_KIND;
    idx[1]  = CFG_DEF_FG_VALUE;
    idx[2]  = CFG_DEF_BG_KIND;
    idx[3]  = CFG_DEF_BG_VALUE;
    data[0] = {junk[CfgDataW-1:KindW], d.fg_kind};
    data[1] = d.fg_value;
    data[2] = {~junk[CfgDataW-1:KindW], d.bg_kind};
    data[3] = d.bg_value;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= data[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // a code from one of the known groups, now and then an unassigned one
  function automatic logic [ParamW-1:0] pick_code();
    case ($urandom_range(7))
      0: return ParamW'($urandom_range(SGR_CROSSED, SGR_BOLD));
      1: return ParamW'($urandom_range(SGR_NO_CROSSED, SGR_FRAKTUR));
      2: return ParamW'($urandom_range(SGR_FONT_LAST, SGR_FONT_FIRST));
      3: return $urandom_range(1) ? ParamW'($urandom_range(SGR_FG_LAST, SGR_FG_FIRST))
                                 : ParamW'($urandom_range(SGR_FG_BRIGHT_LAST,
                                                          SGR_FG_BRIGHT_FIRST));
      4: return $urandom_range(1) ? ParamW'($urandom_range(SGR_BG_LAST, SGR_BG_FIRST))
                                 : ParamW'($urandom_range(SGR_BG_BRIGHT_LAST,
                                                          SGR_BG_BRIGHT_FIRST));
      5: return SGR_RESET;
      6: return $urandom_range(1) ? SGR_FG_DEFAULT : SGR_BG_DEFAULT;
      default: return ParamW'($urandom_range(SGR_BG_BRIGHT_LAST + 20));
    endcase
  endfunction

  // colour bytes are mostly in range, sometimes full 16 bit to hit the masking
  function automatic logic [ParamW-1:0] color_byte();
    return ($urandom_range(4) == 0) ? ParamW'($urandom) : ParamW'($urandom_range(255));
  endfunction

  // one sgr sequence of a few chunks: plain codes, extended colour forms,
  // odd selectors and raw noise; some forms get cut short, which leaves the
  // next chunk (or the next sequence) to land in the middle of them
  task automatic send_random_sequence();
    logic [ParamW-1:0] form [5];
    int unsigned       parts;
    int unsigned       keep;
    int unsigned       len;
    logic              first;
    len = $urandom_range(6, 1);
    // a few sequences go on without the start flag
    first = ($urandom_range(99) >= 5);
    for (int k = 0; k < len; k++) begin
      form[0] = $urandom_range(1) ? SGR_FG_EXT : SGR_BG_EXT;
      parts   = 1;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: form[0] = pick_code();
        5: begin
          form[1] = SEL_INDEXED;
          form[2] = color_byte();
          parts   = 3;
        end
        6, 7: begin
          form[1] = SEL_TRUECOLOR;
          form[2] = color_byte();
          form[3] = color_byte();
          form[4] = color_byte();
          parts   = 5;
        end
        8: begin
          // selector from a small range, unknown ones included
          form[1] = ParamW'($urandom_range(9));
          parts   = 2;
        end
        default: form[0] = ParamW'($urandom);
      endcase
      keep = (parts > 1 && $urandom_range(9) == 0) ? $urandom_range(parts - 1, 1) : parts;
      for (int j = 0; j < keep; j++) begin
        put_param(form[j], first);
        first = 1'b0;
      end
    end
  endtask

  task automatic send_beats(input int unsigned count);
    int unsigned stop_at;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) send_random_sequence();
  endtask

  // ---------------------------------------------------------------------------
  // attribute receiver: random ready, a quiet mode, and long hold-offs on request
  // ---------------------------------------------------------------------------
  initial begin : sink_side
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left     = 0;
    holds_served  = 0;
    attr_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = SINK_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        attr_ch.ready <= 1'b0;
      end else begin
        attr_ch.ready <= !rst && (sink_quiet || $urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run once no beat has moved on either channel for too long
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((param_ch.valid && param_ch.ready) || (attr_ch.valid && attr_ch.ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("[sgr_attribute_tracker] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    defaults_t d;
    src_quiet                  = 1'b0;
    beats_sent                 = 0;
    rst                        <= 1'b1;
    cfg_we                     <= 1'b0;
    cfg_index                  <= '0;
    cfg_data                   <= '0;
    sink_quiet                 <= 1'b0;
    hold_requests              <= 0;
    param_ch.valid             <= 1'b0;
    param_ch.param_value       <= '0;
    param_ch.first_of_sequence <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // --- directed, defaults still zero from reset ---

    // every style flag and both blink modes in one sequence, then both font ends
    for (int c = SGR_BOLD; c <= SGR_CROSSED; c++) put_param(ParamW'(c), c == SGR_BOLD);
    put_param(SGR_FRAKTUR, 1'b0);
    put_param(SGR_FONT_FIRST, 1'b0);
    put_param(SGR_FONT_LAST, 1'b0);
    // every clear code, the double clears included
    put_param(SGR_NO_BOLD, 1'b1);
    put_param(SGR_NORMAL_WEIGHT, 1'b0);
    put_param(SGR_NO_ITALIC, 1'b0);
    put_param(SGR_NO_UNDERLINE, 1'b0);
    put_param(SGR_NO_BLINK, 1'b0);
    put_param(SGR_NO_REVERSE, 1'b0);
    put_param(SGR_NO_CONCEAL, 1'b0);
    put_param(SGR_NO_CROSSED, 1'b0);
    // system colours at one end of each of the four ranges, then unknown codes
    put_param(SGR_FG_FIRST, 1'b1);
    put_param(SGR_BG_BRIGHT_LAST, 1'b0);
    put_param(SGR_FG_BRIGHT_LAST, 1'b0);
    put_param(SGR_BG_FIRST, 1'b0);
    put_param(SGR_UNKNOWN, 1'b0);
    put_param(PARAM_MAX, 1'b0);
    // palette index keeps only the low byte
    put_param(SGR_FG_EXT, 1'b1);
    put_param(SEL_INDEXED, 1'b0);
    put_param(PARAM_MAX, 1'b0);
    // truecolor clears the value at the selector, then takes r, g, b low bytes
    put_param(SGR_BG_EXT, 1'b0);
    put_param(SEL_TRUECOLOR, 1'b0);
    put_param(PARAM_MAX, 1'b0);
    put_param(16'h0100, 1'b0);
    put_param(16'h00A5, 1'b0);
    // an unknown selector is swallowed and decoding goes back to normal
    put_param(SGR_FG_EXT, 1'b1);
    put_param(SGR_UNKNOWN, 1'b0);
    put_param(SGR_BOLD, 1'b0);
    // a new sequence abandons a half-done truecolor form and a pending index
    put_param(SGR_FG_EXT, 1'b1);
    put_param(SEL_TRUECOLOR, 1'b0);
    put_param(16'h0012, 1'b0);
    put_param(SGR_BG_EXT, 1'b1);
    put_param(SEL_INDEXED, 1'b0);
    put_param(SGR_ITALIC, 1'b1);

    // --- directed, defaults at their maximum ---
    drain_attrs();
    d = '{fg_kind: KIND_TRUECOLOR, fg_value: '1, bg_kind: KIND_TRUECOLOR, bg_value: '1};
    set_defaults(d);
    // the write alone must not touch the current colours
    put_param(SGR_UNKNOWN, 1'b1);
    put_param(SGR_FG_DEFAULT, 1'b0);
    put_param(SGR_BG_DEFAULT, 1'b0);
    put_param(SGR_FG_FIRST, 1'b0);
    put_param(SGR_RESET, 1'b0);

    // --- random rounds, one defaults setting each ---
    for (int round = 0; round < ROUNDS; round++) begin
      drain_attrs();
      case (round)
        0: ;  // keep the all-ones defaults
        1: d = '{fg_kind: KIND_SYSTEM, fg_value: ColorW'($urandom),
                 bg_kind: KIND_INDEXED, bg_value: ColorW'($urandom)};
        2: d = '{fg_kind: KIND_INDEXED, fg_value: ColorW'($urandom),
                 bg_kind: KIND_TRUECOLOR, bg_value: ColorW'($urandom)};
        3: d = '{fg_kind: KIND_DEFAULT, fg_value: '0, bg_kind: KIND_DEFAULT, bg_value: '0};
        default: d = '{fg_kind: KindW'($urandom), fg_value: ColorW'($urandom),
                       bg_kind: KindW'($urandom), bg_value: ColorW'($urandom)};
      endcase
      if (round != 0) set_defaults(d);

      if (round == 0) begin
        // receiver holds off while the source keeps pushing, so the output
        // buffer fills and param ready has to drop
        src_quiet = 1'b1;
        hold_requests <= hold_requests + 1;
        send_beats(60);
        src_quiet = 1'b0;
      end else if (round == 1) begin
        // a long stretch at full rate on both sides
        src_quiet = 1'b1;
        sink_quiet <= 1'b1;
        send_beats(80);
        src_quiet = 1'b0;
        sink_quiet <= 1'b0;
      end
      send_beats(BEATS_PER_ROUND);
    end

    // let any stray beat show up before the verdict
    drain_attrs();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("[sgr_attribute_tracker] OK");
    end else begin
      $display("[sgr_attribute_tracker] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sgr_pkg.sv
src/sgr_ifaces.sv
src/sgr_decode.sv
src/sgr_out_buf.sv
src/sgr_attribute_tracker.sv
sim/sgr_tb_pkg.sv
sim/sgr_attr_checker.sv
sim/tb_top.sv
